// ===== rtl/cle_pkg.sv =====
package cle_pkg;

  // Codes for both the queued operation and the reported action.
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_ECHO  = 2'd1,
    ACT_ERASE = 2'd2,
    ACT_LINE  = 2'd3
  } act_e;

  localparam int KeyCount = 28;
  localparam int KeySpan  = 8;

  localparam logic [7:0] CHAR_ERASE   = 8'h08;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TILDE   = 8'h7E;

  localparam logic [4:0] CODE_EMPTY   = 5'd0;
  localparam logic [4:0] CODE_UNKNOWN = 5'd29;

  localparam logic [KeyCount-1:0] ALL_HITS = '1;

  // Widest line index the count field can carry (line capacity up to 256).
  localparam int CountW = 8;

  // One operation handed from the front end to the back end.
  typedef struct packed {
    act_e              op;
    logic [6:0]        data;   // byte to store and echo
    logic [CountW-1:0] count;  // store index for an echo, line length for a line end
  } q_item_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [6:0] line_length;
    logic [6:0] args_start;
    logic [4:0] command;
    logic [6:0] echo_byte;
    act_e       action;
  } result_t;

  // Keyword text, right-justified in 64 bits as string literals are.
  function automatic logic [63:0] key_word(input logic [4:0] k);
    logic [63:0] w;
    case (k)
      5'd0:    w = 64'("help");
      5'd1:    w = 64'("clear");
      5'd2:    w = 64'("echo");
      5'd3:    w = 64'("about");
      5'd4:    w = 64'("version");
      5'd5:    w = 64'("calc");
      5'd6:    w = 64'("banner");
      5'd7:    w = 64'("meminfo");
      5'd8:    w = 64'("memmap");
      5'd9:    w = 64'("frames");
      5'd10:   w = 64'("alloc");
      5'd11:   w = 64'("free");
      5'd12:   w = 64'("heap");
      5'd13:   w = 64'("kmalloc");
      5'd14:   w = 64'("kfree");
      5'd15:   w = 64'("paging");
      5'd16:   w = 64'("virt");
      5'd17:   w = 64'("map");
      5'd18:   w = 64'("unmap");
      5'd19:   w = 64'("fault");
      5'd20:   w = 64'("serial");
      5'd21:   w = 64'("uptime");
      5'd22:   w = 64'("ps");
      5'd23:   w = 64'("spawn");
      5'd24:   w = 64'("kill");
      5'd25:   w = 64'("sleep");
      5'd26:   w = 64'("reboot");
      5'd27:   w = 64'("halt");
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] key_len(input logic [4:0] k);
    logic [3:0] l;
    case (k)
      5'd22:                                  l = 4'd2;
      5'd17:                                  l = 4'd3;
      5'd0, 5'd2, 5'd5, 5'd11, 5'd12, 5'd16,
      5'd24, 5'd27:                           l = 4'd4;
      5'd1, 5'd3, 5'd10, 5'd14, 5'd18, 5'd19,
      5'd23, 5'd25:                           l = 4'd5;
      5'd6, 5'd8, 5'd9, 5'd15, 5'd20, 5'd21,
      5'd26:                                  l = 4'd6;
      5'd4, 5'd7, 5'd13:                      l = 4'd7;
      default:                                l = 4'd0;
    endcase
    return l;
  endfunction

  // Character at position p of keyword k; zero past its end.
  function automatic logic [7:0] key_char(input logic [4:0] k, input logic [2:0] p);
    logic [63:0] w;
    logic [3:0]  l;
    logic [2:0]  sel;
    logic [7:0]  c;
    w   = key_word(k);
    l   = key_len(k);
    sel = 3'(l - 4'd1 - {1'b0, p});
    c   = 8'h00;
    if ({1'b0, p} < l) begin
      c = w[{sel, 3'b000} +: 8];
    end
    return c;
  endfunction

endpackage

// ===== rtl/console_line_editor_command_match.sv =====
// Channel  | Direction | tdata (low bit up)                                    | tuser/tlast
// s_axis   | in        | ch[7:0]                                               | none
// m_axis   | out       | action[1:0] echo_byte[8:2] command[13:9]              | none
//          |           | args_start[20:14] line_length[27:21], zero to bit 31  |
// A byte is classified and queued at the edge that accepts it; erase, echo and ignored bytes
// load the result register at the edge that pops them from the queue.
// A newline walks the first word one stored byte per cycle through the line store read port.
// The two-entry queue lets bytes be taken while a walk runs or a result waits for m_axis_tready.
// rst_ni clears the fill count, queue and sequencer; the line store needs no clearing.
module console_line_editor_command_match import cle_pkg::*; #(
  parameter int LINE_CAPACITY = 128,
  parameter int WORD_LIMIT    = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // ch[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // action, echo_byte, command, args_start, line_length
);

  q_item_t push_item, pop_item;
  logic    push, full, pop, q_valid;
  result_t result;

  cle_front #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .ch_i       (s_axis_tdata),
    .push_o     (push),
    .full_i     (full),
    .item_o     (push_item)
  );

  cle_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  cle_back #(
    .LINE_CAPACITY(LINE_CAPACITY),
    .WORD_LIMIT   (WORD_LIMIT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result)
  );

  // Results packed from the lowest bit up, padded to whole bytes.
  assign m_axis_tdata = {4'd0, result};

endmodule

// ===== rtl/cle_front.sv =====
module cle_front import cle_pkg::*; #(
  parameter int LINE_CAPACITY = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  output logic       push_o,
  input  logic       full_i,
  output q_item_t    item_o
);

  localparam int IW = $clog2(LINE_CAPACITY);

  logic [IW-1:0] fill_q, fill_d;
  logic          take;

  assign in_ready_o = !full_i;
  assign take       = in_valid_i && !full_i;
  assign push_o     = take;

  // Classify the byte and keep the line fill count.
  always_comb begin
    fill_d      = fill_q;
    item_o.op   = ACT_NONE;
    item_o.data = '0;
    item_o.count = CountW'(fill_q);
    if (ch_i == CHAR_ERASE) begin
      if (fill_q != '0) begin
        item_o.op = ACT_ERASE;
        fill_d    = fill_q - IW'(1);
      end
    end else if (ch_i == CHAR_NEWLINE) begin
      item_o.op = ACT_LINE;
      fill_d    = '0;
    end else if (ch_i inside {[CHAR_SPACE:CHAR_TILDE]}) begin
      if ({1'b0, fill_q} < (IW+1)'(LINE_CAPACITY - 1)) begin
        item_o.op   = ACT_ECHO;
        item_o.data = ch_i[6:0];
        fill_d      = fill_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (take) begin
      fill_q <= fill_d;
    end
  end

endmodule

// ===== rtl/cle_queue.sv =====
module cle_queue import cle_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t push_item_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output q_item_t pop_item_o
);

  q_item_t     slot_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_item_o = slot_q[rd_ptr_q];

  // Entry storage, no reset needed.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  push_when_full_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("queue written while full");
  pop_when_empty_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o)) else $error("queue read while empty");
  count_step_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q != 2'd0) else $error("occupancy lost a push");

endmodule

// ===== rtl/cle_back.sv =====
module cle_back import cle_pkg::*; #(
  parameter int LINE_CAPACITY = 128,
  parameter int WORD_LIMIT    = 31
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  q_item_t item_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  localparam int IW = $clog2(LINE_CAPACITY);
  localparam int WW = $clog2(WORD_LIMIT + 1);
  localparam int CW = ((IW > WW) ? IW : WW) + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]          st_q, st_d;
  logic [WW-1:0]       pos_q, pos_d, pos_inc;
  logic [IW-1:0]       len_q, len_d;
  logic [KeyCount-1:0] hits_q, hits_d, final_hits;
  logic                out_valid_q, out_valid_d, out_free, load;
  result_t             out_q, out_d;
  logic [4:0]          code;

  logic [7:0]          mem_q [LINE_CAPACITY];
  logic [7:0]          rd_data_q;
  logic [IW-1:0]       rd_addr;
  logic                wr_en;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;
  assign pos_inc     = pos_q + WW'(1);

  // Line store: one write port, one registered read port.
  assign wr_en = pop_o && (item_i.op == ACT_ECHO);
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[item_i.count[IW-1:0]] <= {1'b0, item_i.data};
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Keep only keywords whose length equals the walked word, first one wins.
  always_comb begin
    code = CODE_UNKNOWN;
    for (int k = KeyCount - 1; k >= 0; k--) begin
      final_hits[k] = hits_q[k] && ({4'd0, key_len(5'(k))} == 8'(pos_q));
      if (final_hits[k]) begin
        code = 5'(k + 1);
      end
    end
  end

  // Sequencer for simple operations and the first-word walk.
  always_comb begin
    st_d    = st_q;
    pos_d   = pos_q;
    len_d   = len_q;
    hits_d  = hits_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    out_d   = '0;
    rd_addr = '0;
    case (st_q)
      ST_IDLE: begin
        if (valid_i) begin
          if (item_i.op == ACT_LINE) begin
            pop_o  = 1'b1;
            len_d  = item_i.count[IW-1:0];
            pos_d  = '0;
            hits_d = ALL_HITS;
            st_d   = (item_i.count[IW-1:0] == '0) ? ST_EMIT : ST_WALK;
          end else if (out_free) begin
            pop_o         = 1'b1;
            load          = 1'b1;
            out_d.action  = item_i.op;
            out_d.echo_byte = (item_i.op == ACT_ECHO) ? item_i.data : 7'd0;
          end
        end
      end
      ST_WALK: begin
        rd_addr = IW'(pos_inc);
        if (rd_data_q == CHAR_SPACE) begin
          st_d = ST_EMIT;
        end else begin
          for (int k = 0; k < KeyCount; k++) begin
            hits_d[k] = hits_q[k] && (CW'(pos_q) < CW'(KeySpan)) &&
                        (key_char(5'(k), pos_q[2:0]) == rd_data_q);
          end
          pos_d = pos_inc;
          if (!(CW'(pos_inc) < CW'(len_q) && CW'(pos_inc) < CW'(WORD_LIMIT))) begin
            st_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load              = 1'b1;
          out_d.action      = ACT_LINE;
          out_d.command     = (len_q == '0) ? CODE_EMPTY : code;
          out_d.args_start  = (CW'(pos_q) < CW'(len_q)) ? 7'(CW'(pos_q) + CW'(1))
                                                        : 7'(pos_q);
          out_d.line_length = 7'(len_q);
          st_d              = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Output register holds a result until it is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      pos_q       <= '0;
      len_q       <= '0;
      hits_q      <= ALL_HITS;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      pos_q       <= pos_d;
      len_q       <= len_d;
      hits_q      <= hits_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  walk_in_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_WALK |-> (CW'(pos_q) < CW'(len_q)) && (CW'(pos_q) < CW'(WORD_LIMIT)))
    else $error("word walk beyond line or word limit");
  simple_op_emits_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && item_i.op != ACT_LINE |=> out_valid_q)
    else $error("simple operation produced no result");
  command_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.action == ACT_LINE |-> out_q.command <= CODE_UNKNOWN)
    else $error("command code out of range");
  walk_no_pop_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != ST_IDLE |-> !pop_o)
    else $error("queue read during a walk");

endmodule
